// File: rtl/pclv_pkg.sv
// Shared types, constants and the check-letter map for the plate check-letter validator.
package pclv_pkg;

    // Character and field widths
    localparam int CharW     = 8;
    localparam int LetterW   = 7;
    localparam int SumW      = 9;   // largest weighted sum is 464
    localparam int RemW      = 5;   // remainder 0..18
    localparam int PosW      = 4;
    localparam int CountW    = 3;
    localparam int DigitW    = 4;
    localparam int NumDigits = 4;
    localparam int ValW      = 5;   // letter code A=1..Z=26

    // Longest accepted string
    localparam logic [PosW-1:0] MaxChars = PosW'(8);
    localparam logic [PosW-1:0] PosMax   = '1;

    localparam logic [SumW-1:0] Modulus  = SumW'(19);

    // Characters with a fixed role
    localparam logic [CharW-1:0] CharS    = 8'h53;
    localparam logic [CharW-1:0] CharH    = 8'h48;
    localparam logic [CharW-1:0] CharZ    = 8'h5A;
    localparam logic [CharW-1:0] CharG    = 8'h47;
    localparam logic [CharW-1:0] CharA    = 8'h41;
    localparam logic [CharW-1:0] CharE    = 8'h45;
    localparam logic [CharW-1:0] CharI    = 8'h49;
    localparam logic [CharW-1:0] CharO    = 8'h4F;
    localparam logic [CharW-1:0] CharU    = 8'h55;
    localparam logic [CharW-1:0] CharZero = 8'h30;
    localparam logic [CharW-1:0] CharNine = 8'h39;

    // Vehicle class codes
    localparam logic [1:0] ClassTaxi    = 2'd0;
    localparam logic [1:0] ClassRental  = 2'd1;
    localparam logic [1:0] ClassGoods   = 2'd2;
    localparam logic [1:0] ClassPrivate = 2'd3;

    // Per-string summary handed from the parser to the check stage
    typedef struct packed {
        logic [SumW-1:0]  sum;
        logic [1:0]       vclass;
        logic [CharW-1:0] check_letter;
        logic             fmt_ok;      // format good, check letter seen, number nonzero
    } parse_res_t;

    // Remainder mod 19 to ASCII check letter: AZYXUTSRPMLKJHGEDCB
    function automatic logic [LetterW-1:0] map_letter(input logic [RemW-1:0] r);
        logic [LetterW-1:0] l;
        unique case (r)
            5'd0:    l = 7'h41; // A
            5'd1:    l = 7'h5A; // Z
            5'd2:    l = 7'h59; // Y
            5'd3:    l = 7'h58; // X
            5'd4:    l = 7'h55; // U
            5'd5:    l = 7'h54; // T
            5'd6:    l = 7'h53; // S
            5'd7:    l = 7'h52; // R
            5'd8:    l = 7'h50; // P
            5'd9:    l = 7'h4D; // M
            5'd10:   l = 7'h4C; // L
            5'd11:   l = 7'h4B; // K
            5'd12:   l = 7'h4A; // J
            5'd13:   l = 7'h48; // H
            5'd14:   l = 7'h47; // G
            5'd15:   l = 7'h45; // E
            5'd16:   l = 7'h44; // D
            5'd17:   l = 7'h43; // C
            5'd18:   l = 7'h42; // B
            default: l = 7'h41;
        endcase
        return l;
    endfunction

endpackage

// File: rtl/plate_check_letter_validator_top.sv
// Top level of the plate check-letter validator: input register, parser, mod-19 check stage.
//
// Input stream (s_): one ASCII character per word in s_tdata, s_tlast on the
// final character of a registration string. Result stream (m_): one word per
// string, sent for the word that carried s_tlast; no word for other characters.
// A result word holds the valid flag, the vehicle class and the expected check
// letter.
//
// Path: the last character moves from the input register into the sum register,
// then into the result register, which drives m_tvalid.
// Throughput: one character per cycle while s_tready is high; the parser state
// updates once per character, and the mod-19 reduction sits in its own stage
// behind the sum register.
//
// Reset (aresetn low, synchronous) empties all stages and starts a fresh
// string. If the receiver holds m_tready low, the result register keeps its
// word; characters that end no string keep flowing, and s_tready drops only
// while both the result and sum registers hold words and a last character waits.
module plate_check_letter_validator_top import pclv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] char_code
    input  logic        s_tlast,     // is_last
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata      // [0] valid_res, [2:1] vehicle_class,
                                     // [9:3] expected_letter, [15:10] zero
);

    logic             in_valid_reg;
    logic [CharW-1:0] in_char_reg;
    logic             in_last_reg;

    logic             sum_valid_reg;
    parse_res_t       sum_res_reg;

    logic             out_valid_reg;
    logic             out_ok_reg;
    logic [1:0]       out_class_reg;
    logic [LetterW-1:0] out_letter_reg;

    logic out_ready, sum_ready, consume;
    parse_res_t parse_res;

    logic [SumW+5-1:0] quot_prod;
    logic [SumW-1:0]   quot, rem_raw, rem;
    logic [LetterW-1:0] exp_letter;

    // Stage flow control
    assign out_ready = !out_valid_reg || m_tready;
    assign sum_ready = !sum_valid_reg || out_ready;
    assign consume   = in_valid_reg && (!in_last_reg || sum_ready);
    assign s_tready  = !in_valid_reg || consume;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    pclv_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .consume   (consume),
        .char_code (in_char_reg),
        .is_last   (in_last_reg),
        .res       (parse_res)
    );

    // Sum register, loaded at the end of each string
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            sum_valid_reg <= consume && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && consume && in_last_reg) sum_res_reg <= parse_res;
    end

    // Mod 19: quotient estimate sum*26/512 is low by at most one
    assign quot_prod  = (SumW+5)'(sum_res_reg.sum) * (SumW+5)'(26);
    assign quot       = SumW'(quot_prod >> 9);
    assign rem_raw    = sum_res_reg.sum - SumW'(quot * Modulus);
    assign rem        = (rem_raw >= Modulus) ? (rem_raw - Modulus) : rem_raw;
    assign exp_letter = map_letter(rem[RemW-1:0]);

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && sum_valid_reg) begin
            out_ok_reg     <= sum_res_reg.fmt_ok
                           && (sum_res_reg.check_letter == {1'b0, exp_letter});
            out_class_reg  <= sum_res_reg.vclass;
            out_letter_reg <= exp_letter;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_letter_reg, out_class_reg, out_ok_reg};

endmodule

// File: rtl/pclv_parser.sv
// Per-string format parser: tracks position, letters and digits, forms the weighted sum.
module pclv_parser import pclv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             consume,     // a character leaves the input register
    input  logic [CharW-1:0] char_code,
    input  logic             is_last,
    output parse_res_t       res          // summary including the consumed character
);

    logic [PosW-1:0]   position_reg, position_next;
    logic              format_error_reg, format_error_next;
    logic [ValW-1:0]   first_val_reg, first_val_next;
    logic [ValW-1:0]   second_val_reg, second_val_next;
    logic [DigitW-1:0] digit_store_reg [NumDigits];
    logic [DigitW-1:0] digit_store_next [NumDigits];
    logic [CountW-1:0] digit_count_reg, digit_count_next;
    logic              nonzero_reg, nonzero_next;
    logic              check_seen_reg, check_seen_next;
    logic [CharW-1:0]  check_letter_reg, check_letter_next;
    logic [1:0]        class_reg, class_next;

    logic is_upper, is_digit, is_vowel;
    logic [SumW-1:0] letter_sum, digit_sum;

    assign is_upper = (char_code >= CharA) && (char_code <= CharZ);
    assign is_digit = (char_code >= CharZero) && (char_code <= CharNine);
    assign is_vowel = (char_code == CharA) || (char_code == CharE) || (char_code == CharI)
                   || (char_code == CharO) || (char_code == CharU);

    // Next state for the character in hand
    always_comb begin
        position_next     = position_reg;
        format_error_next = format_error_reg;
        first_val_next    = first_val_reg;
        second_val_next   = second_val_reg;
        digit_store_next  = digit_store_reg;
        digit_count_next  = digit_count_reg;
        nonzero_next      = nonzero_reg;
        check_seen_next   = check_seen_reg;
        check_letter_next = check_letter_reg;
        class_next        = class_reg;

        priority if (position_reg >= MaxChars || check_seen_reg) begin
            format_error_next = 1'b1;
        end else if (position_reg == PosW'(0)) begin
            if (char_code != CharS) format_error_next = 1'b1;
        end else if (position_reg == PosW'(1)) begin
            if (!is_upper || is_vowel) begin
                format_error_next = 1'b1;
            end else begin
                first_val_next = char_code[ValW-1:0];
                priority if (char_code == CharH) class_next = ClassTaxi;
                else if (char_code == CharZ)     class_next = ClassRental;
                else if (char_code == CharG)     class_next = ClassGoods;
                else                             class_next = ClassPrivate;
            end
        end else if (position_reg == PosW'(2)) begin
            if (!is_upper) format_error_next = 1'b1;
            else second_val_next = char_code[ValW-1:0];
        end else if (is_digit) begin
            if (digit_count_reg >= CountW'(NumDigits)) begin
                format_error_next = 1'b1;
            end else begin
                digit_store_next[digit_count_reg[1:0]] = char_code[DigitW-1:0];
                if (char_code != CharZero) nonzero_next = 1'b1;
                digit_count_next = digit_count_reg + CountW'(1);
            end
        end else if (is_upper && digit_count_reg != '0) begin
            check_seen_next   = 1'b1;
            check_letter_next = char_code;
        end else begin
            format_error_next = 1'b1;
        end

        if (position_reg != PosMax) position_next = position_reg + PosW'(1);
    end

    // Weighted sum, digits right-aligned onto weights 5,4,3,2
    assign letter_sum = SumW'(9) * SumW'(first_val_next) + SumW'(4) * SumW'(second_val_next);

    always_comb begin
        unique case (digit_count_next)
            3'd0: digit_sum = '0;
            3'd1: digit_sum = SumW'(2) * SumW'(digit_store_next[0]);
            3'd2: digit_sum = SumW'(3) * SumW'(digit_store_next[0])
                            + SumW'(2) * SumW'(digit_store_next[1]);
            3'd3: digit_sum = SumW'(4) * SumW'(digit_store_next[0])
                            + SumW'(3) * SumW'(digit_store_next[1])
                            + SumW'(2) * SumW'(digit_store_next[2]);
            default: digit_sum = SumW'(5) * SumW'(digit_store_next[0])
                               + SumW'(4) * SumW'(digit_store_next[1])
                               + SumW'(3) * SumW'(digit_store_next[2])
                               + SumW'(2) * SumW'(digit_store_next[3]);
        endcase
    end

    assign res.sum          = letter_sum + digit_sum;
    assign res.vclass       = class_next;
    assign res.check_letter = check_letter_next;
    assign res.fmt_ok       = !format_error_next && check_seen_next && nonzero_next;

    // Per-string state; cleared after the last character of a string
    always_ff @(posedge aclk) begin
        if (!aresetn || (consume && is_last)) begin
            position_reg     <= '0;
            format_error_reg <= 1'b0;
            first_val_reg    <= '0;
            second_val_reg   <= '0;
            digit_count_reg  <= '0;
            nonzero_reg      <= 1'b0;
            check_seen_reg   <= 1'b0;
            check_letter_reg <= '0;
            class_reg        <= ClassPrivate;
        end else if (consume) begin
            position_reg     <= position_next;
            format_error_reg <= format_error_next;
            first_val_reg    <= first_val_next;
            second_val_reg   <= second_val_next;
            digit_count_reg  <= digit_count_next;
            nonzero_reg      <= nonzero_next;
            check_seen_reg   <= check_seen_next;
            check_letter_reg <= check_letter_next;
            class_reg        <= class_next;
        end
    end

    // Digit buffer, only entries written in the current string are read
    always_ff @(posedge aclk) begin
        if (consume) digit_store_reg <= digit_store_next;
    end

endmodule
